@@ sv/lcs_pkg.sv @@
`timescale 1ns / 1ps

package lcs_pkg;

    localparam int WS_DEPTH = 32;
    localparam int CNT_W    = $clog2(WS_DEPTH + 1);
    localparam int IDX_W    = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;

    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_SP  = 8'd32;
    localparam logic [7:0] CH_DQ  = 8'h22;
    localparam logic [7:0] CH_SQ  = 8'h27;
    localparam logic [7:0] CH_SL  = 8'h2F;
    localparam logic [7:0] CH_BSL = 8'h5C;

    typedef enum logic [1:0] {
        SEL_BLANK,
        SEL_SLASH,
        SEL_BYTE,
        SEL_NL
    } emit_sel_t;

    typedef struct packed {
        logic      take;
        logic      emit;
        emit_sel_t sel;
        logic      last;
        logic      ov_en;
    } lcs_cmd_t;

    typedef struct packed {
        logic dec_flush;
        logic dec_slash;
        logic dec_byte;
        logic dec_nl;
        logic flush_last;
        logic out_free;
    } lcs_sts_t;

endpackage

@@ sv/lcs_in_if.sv @@
`timescale 1ns / 1ps

interface lcs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

@@ sv/lcs_out_if.sv @@
`timescale 1ns / 1ps

interface lcs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       blank_overflow;

    modport source (output valid, output out_byte, output last_of_run,
                    output blank_overflow, input ready);
    modport sink (input valid, input out_byte, input last_of_run,
                  input blank_overflow, output ready);
endinterface

@@ sv/line_comment_stripper_core.sv @@
`timescale 1ns / 1ps

// Channel    Role   Payload
// raw        sink   in_byte[7:0], end_of_input
// stripped   source out_byte[7:0], last_of_run, blank_overflow
//
// An item is taken first; the results it causes are then loaded one by one, each when the result register is free.
// A plain byte thus yields one result; a flushed run of N blanks adds N results.
// The sequencer takes no item until the results of the last one are all loaded.
// The result register lets a new item in while the last beat waits for ready.
// Reset clears the line state and the blank count; the blank buffer holds no reset.

module line_comment_stripper_core
(
    input  logic clk,
    input  logic rst_n,
    lcs_in_if.sink    raw,
    lcs_out_if.source stripped
);

    lcs_pkg::lcs_cmd_t cmd;
    lcs_pkg::lcs_sts_t sts;

    lcs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (raw.valid),
        .in_ready (raw.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lcs_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_byte        (raw.in_byte),
        .end_of_input   (raw.end_of_input),
        .cmd            (cmd),
        .sts            (sts),
        .out_valid      (stripped.valid),
        .out_ready      (stripped.ready),
        .out_byte       (stripped.out_byte),
        .last_of_run    (stripped.last_of_run),
        .blank_overflow (stripped.blank_overflow)
    );

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result loaded into an occupied output register");

    a_take_xor_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.take && cmd.emit))
        else $error("item taken while results are still being sequenced");

    a_newline_last: assert property (@(posedge clk) disable iff (!rst_n)
        (stripped.valid && (stripped.out_byte == lcs_pkg::CH_LF))
        |-> (stripped.last_of_run && !stripped.blank_overflow))
        else $error("newline beat is not the clean final beat of its item");

endmodule

@@ sv/lcs_ctrl.sv @@
`timescale 1ns / 1ps

module lcs_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  lcs_pkg::lcs_sts_t sts,
    output lcs_pkg::lcs_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_SLASH,
        ST_BYTE,
        ST_NL
    } state_t;

    state_t state_reg, state_next;
    logic   p_slash_reg, p_slash_next;
    logic   p_byte_reg, p_byte_next;
    logic   p_nl_reg, p_nl_next;

    state_t after_flush, after_slash, after_byte;

    always_comb
    begin
        after_byte  = p_nl_reg ? ST_NL : ST_IDLE;
        after_slash = p_byte_reg ? ST_BYTE : after_byte;
        after_flush = p_slash_reg ? ST_SLASH : after_slash;
    end

    always_comb
    begin
        state_next   = state_reg;
        p_slash_next = p_slash_reg;
        p_byte_next  = p_byte_reg;
        p_nl_next    = p_nl_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.sel      = lcs_pkg::SEL_BLANK;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take     = 1'b1;
                    p_slash_next = sts.dec_slash;
                    p_byte_next  = sts.dec_byte;
                    p_nl_next    = sts.dec_nl;
                    if (sts.dec_flush)
                        state_next = ST_FLUSH;
                    else if (sts.dec_slash)
                        state_next = ST_SLASH;
                    else if (sts.dec_byte)
                        state_next = ST_BYTE;
                    else if (sts.dec_nl)
                        state_next = ST_NL;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.emit  = 1'b1;
                    cmd.sel   = lcs_pkg::SEL_BLANK;
                    cmd.ov_en = 1'b1;
                    cmd.last  = sts.flush_last && (after_flush == ST_IDLE);
                    if (sts.flush_last)
                        state_next = after_flush;
                end
            end
            ST_SLASH:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = lcs_pkg::SEL_SLASH;
                    cmd.ov_en  = 1'b1;
                    cmd.last   = (after_slash == ST_IDLE);
                    state_next = after_slash;
                end
            end
            ST_BYTE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = lcs_pkg::SEL_BYTE;
                    cmd.ov_en  = !p_slash_reg;
                    cmd.last   = (after_byte == ST_IDLE);
                    state_next = after_byte;
                end
            end
            ST_NL:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = lcs_pkg::SEL_NL;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            p_slash_reg <= 1'b0;
            p_byte_reg  <= 1'b0;
            p_nl_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            p_slash_reg <= p_slash_next;
            p_byte_reg  <= p_byte_next;
            p_nl_reg    <= p_nl_next;
        end
    end

endmodule

@@ sv/lcs_dp.sv @@
`timescale 1ns / 1ps

module lcs_dp
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        in_byte,
    input  logic              end_of_input,
    input  lcs_pkg::lcs_cmd_t cmd,
    output lcs_pkg::lcs_sts_t sts,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              last_of_run,
    output logic              blank_overflow
);

    logic                      in_str_reg, in_str_next;
    logic                      in_chr_reg, in_chr_next;
    logic                      in_cmt_reg, in_cmt_next;
    logic                      slash_reg, slash_next;
    logic [7:0]                prior_reg, prior_next;
    logic                      has_text_reg, has_text_next;
    logic [lcs_pkg::CNT_W-1:0] count_reg, count_next;
    logic                      ov_seen_reg, ov_seen_next;
    logic [lcs_pkg::IDX_W-1:0] fidx_reg, fidx_next;
    logic [7:0]                byte_reg, byte_next;
    logic                      ov_grp_reg, ov_grp_next;
    logic                      pend_reg, pend_next;
    logic                      pend_tab_reg, pend_tab_next;
    logic                      ovalid_reg, ovalid_next;
    logic [7:0]                obyte_reg, obyte_next;
    logic                      olast_reg, olast_next;
    logic                      oov_reg, oov_next;

    logic                      kinds_mem [lcs_pkg::WS_DEPTH];
    logic                      kw_en;
    logic [lcs_pkg::IDX_W-1:0] kw_addr;
    logic                      kw_data;

    logic fin, is_blank, is_tab, q_str, q_chr, hold, emits, has_blanks, room;

    always_comb
    begin
        fin        = end_of_input || (in_byte == lcs_pkg::CH_LF);
        is_tab     = (in_byte == lcs_pkg::CH_TAB);
        is_blank   = is_tab || (in_byte == lcs_pkg::CH_SP);
        q_str      = (in_byte == lcs_pkg::CH_DQ) && !in_chr_reg
                     && (prior_reg != lcs_pkg::CH_BSL);
        q_chr      = (in_byte == lcs_pkg::CH_SQ) && !in_str_reg
                     && (prior_reg != lcs_pkg::CH_BSL);
        hold       = (in_byte == lcs_pkg::CH_SL) && !in_str_reg && !in_chr_reg;
        emits      = !is_blank && !hold;
        has_blanks = (count_reg != '0);
        room       = (count_reg < lcs_pkg::CNT_W'(lcs_pkg::WS_DEPTH));
    end

    always_comb
    begin
        sts = '0;
        if (fin)
        begin
            sts.dec_flush = slash_reg && has_blanks;
            sts.dec_slash = slash_reg;
            sts.dec_nl    = has_text_reg || slash_reg;
        end
        else if (in_cmt_reg)
        begin
            sts.dec_flush = 1'b0;
        end
        else if (slash_reg)
        begin
            if (in_byte != lcs_pkg::CH_SL)
            begin
                sts.dec_flush = has_blanks;
                sts.dec_slash = 1'b1;
                sts.dec_byte  = !is_blank;
            end
        end
        else
        begin
            sts.dec_flush = emits && has_blanks;
            sts.dec_byte  = emits;
        end
        sts.flush_last = (lcs_pkg::CNT_W'(fidx_reg) == lcs_pkg::CNT_W'(count_reg - 1'b1));
        sts.out_free   = !ovalid_reg || out_ready;
    end

    always_comb
    begin
        in_str_next   = in_str_reg;
        in_chr_next   = in_chr_reg;
        in_cmt_next   = in_cmt_reg;
        slash_next    = slash_reg;
        prior_next    = prior_reg;
        has_text_next = has_text_reg;
        count_next    = count_reg;
        ov_seen_next  = ov_seen_reg;
        fidx_next     = fidx_reg;
        byte_next     = byte_reg;
        ov_grp_next   = ov_grp_reg;
        pend_next     = pend_reg;
        pend_tab_next = pend_tab_reg;
        ovalid_next   = ovalid_reg && !out_ready;
        obyte_next    = obyte_reg;
        olast_next    = olast_reg;
        oov_next      = oov_reg;
        kw_en         = 1'b0;
        kw_addr       = count_reg[lcs_pkg::IDX_W-1:0];
        kw_data       = is_tab;

        if (cmd.take)
        begin
            byte_next     = in_byte;
            ov_grp_next   = ov_seen_reg;
            fidx_next     = '0;
            pend_next     = 1'b0;
            pend_tab_next = is_tab;
            if (fin)
            begin
                in_str_next   = 1'b0;
                in_chr_next   = 1'b0;
                in_cmt_next   = 1'b0;
                slash_next    = 1'b0;
                prior_next    = '0;
                has_text_next = 1'b0;
                if (!slash_reg)
                begin
                    count_next   = '0;
                    ov_seen_next = 1'b0;
                end
            end
            else if (in_cmt_reg)
            begin
                prior_next = in_byte;
            end
            else if (slash_reg)
            begin
                slash_next = 1'b0;
                prior_next = in_byte;
                if (in_byte == lcs_pkg::CH_SL)
                begin
                    in_cmt_next = 1'b1;
                end
                else
                begin
                    has_text_next = 1'b1;
                    pend_next     = is_blank;
                    if (!is_blank && q_str)
                        in_str_next = !in_str_reg;
                    else if (!is_blank && q_chr)
                        in_chr_next = !in_chr_reg;
                end
            end
            else
            begin
                prior_next = in_byte;
                if (is_blank)
                begin
                    if (room)
                    begin
                        kw_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ov_seen_next = 1'b1;
                    end
                end
                else if (q_str)
                begin
                    in_str_next   = !in_str_reg;
                    has_text_next = 1'b1;
                end
                else if (q_chr)
                begin
                    in_chr_next   = !in_chr_reg;
                    has_text_next = 1'b1;
                end
                else if (hold)
                begin
                    slash_next = 1'b1;
                end
                else
                begin
                    has_text_next = 1'b1;
                end
            end
        end

        if (cmd.emit)
        begin
            ovalid_next = 1'b1;
            olast_next  = cmd.last;
            oov_next    = ov_grp_reg && cmd.ov_en;
            case (cmd.sel)
                lcs_pkg::SEL_BLANK:
                begin
                    fidx_next = fidx_reg + 1'b1;
                end
                lcs_pkg::SEL_SLASH:
                begin
                    obyte_next   = lcs_pkg::CH_SL;
                    ov_seen_next = 1'b0;
                    fidx_next    = '0;
                    if (pend_reg)
                    begin
                        kw_en      = 1'b1;
                        kw_addr    = '0;
                        kw_data    = pend_tab_reg;
                        count_next = lcs_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        count_next = '0;
                    end
                end
                lcs_pkg::SEL_BYTE:
                begin
                    obyte_next   = byte_reg;
                    ov_seen_next = 1'b0;
                    count_next   = '0;
                    fidx_next    = '0;
                end
                lcs_pkg::SEL_NL:
                begin
                    obyte_next = lcs_pkg::CH_LF;
                end
                default:
                begin
                    obyte_next = lcs_pkg::CH_LF;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (kw_en)
            kinds_mem[kw_addr] <= kw_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_str_reg   <= 1'b0;
            in_chr_reg   <= 1'b0;
            in_cmt_reg   <= 1'b0;
            slash_reg    <= 1'b0;
            prior_reg    <= '0;
            has_text_reg <= 1'b0;
            count_reg    <= '0;
            ov_seen_reg  <= 1'b0;
            fidx_reg     <= '0;
            pend_reg     <= 1'b0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            in_str_reg   <= in_str_next;
            in_chr_reg   <= in_chr_next;
            in_cmt_reg   <= in_cmt_next;
            slash_reg    <= slash_next;
            prior_reg    <= prior_next;
            has_text_reg <= has_text_next;
            count_reg    <= count_next;
            ov_seen_reg  <= ov_seen_next;
            fidx_reg     <= fidx_next;
            pend_reg     <= pend_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        ov_grp_reg   <= ov_grp_next;
        pend_tab_reg <= pend_tab_next;
        olast_reg    <= olast_next;
        oov_reg      <= oov_next;
        if (cmd.emit && (cmd.sel == lcs_pkg::SEL_BLANK))
            obyte_reg <= kinds_mem[fidx_reg] ? lcs_pkg::CH_TAB : lcs_pkg::CH_SP;
        else
            obyte_reg <= obyte_next;
    end

    assign out_valid      = ovalid_reg;
    assign out_byte       = obyte_reg;
    assign last_of_run    = olast_reg;
    assign blank_overflow = oov_reg;

endmodule
